### rtl/core/bitg_pkg.sv
`default_nettype none

package bitg_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SAMPLE_BITS    = 16;
  localparam int SINE_ADDR_BITS = 10;

  localparam int STEP_BITS      = 32;
  localparam int GAIN_BITS      = 16;
  localparam int ANGLE_BITS     = 16;
  localparam int COUNT_BITS     = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam int SINE_SIZE    = 1 << SINE_ADDR_BITS;
  localparam int QUARTER_BITS = SINE_ADDR_BITS - 2;
  localparam int QUARTER_SIZE = 1 << QUARTER_BITS;
  localparam int MAG_BITS     = SAMPLE_BITS - 1;
  localparam int PROD_BITS    = GAIN_BITS + MAG_BITS;
  localparam int OFF_SHIFT    = PHASE_BITS - 15 - SAMPLE_BITS;

  localparam longint SINE_AMP    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  localparam logic [STEP_BITS-1:0]  TONE_STEP_RST   = 32'd42852281;
  localparam logic [GAIN_BITS-1:0]  ITD_GAIN_RST    = 16'd17288;
  localparam logic [ANGLE_BITS-1:0] ANGLE_STEP_RST  = 16'd104;
  localparam logic [COUNT_BITS-1:0] FRAMES_PER_BUF_RST = 16'd256;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_TONE_STEP  = 2'd0,
    CFG_ITD_GAIN   = 2'd1,
    CFG_ANGLE_STEP = 2'd2,
    CFG_FRAMES     = 2'd3
  } cfg_reg_t;

  typedef logic [MAG_BITS-1:0]              mag_t;
  typedef logic signed [SAMPLE_BITS-1:0]    sample_t;
  typedef logic [SINE_ADDR_BITS-1:0]        sine_addr_t;
  typedef sample_t                          sine_rom_t [SINE_SIZE];
  typedef mag_t                             quarter_rom_t [QUARTER_SIZE];

  // Quarter-wave magnitude by a Taylor series in Q2.30, scaled to the sample amplitude.
  function automatic longint quarter_sine(longint r);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint v;
    x    = (r * HALF_PI_Q30 + QUARTER_SIZE / 2) / QUARTER_SIZE;
    x2   = (x * x + (longint'(1) << 29)) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'sd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'sd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'sd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'sd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'sd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'sd156;
    sum  = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * SINE_AMP + (longint'(1) << 29)) >> 30;
    if (v > SINE_AMP) begin
      v = SINE_AMP;
    end
    return v;
  endfunction

  function automatic longint sine_at(int idx);
    int     quad;
    int     r;
    longint m;
    quad = (idx >> QUARTER_BITS) & 3;
    r    = idx & (QUARTER_SIZE - 1);
    if ((quad & 1) != 0) begin
      m = quarter_sine(longint'(QUARTER_SIZE - r));
    end else begin
      m = quarter_sine(longint'(r));
    end
    if ((quad & 2) != 0) begin
      m = -m;
    end
    return m;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < SINE_SIZE; i++) begin
      rom[i] = sample_t'(sine_at(i));
    end
    return rom;
  endfunction

  function automatic quarter_rom_t build_quarter_rom();
    quarter_rom_t rom;
    for (int i = 0; i < QUARTER_SIZE; i++) begin
      rom[i] = mag_t'(quarter_sine(longint'(i)));
    end
    return rom;
  endfunction

  localparam quarter_rom_t QUARTER_ROM  = build_quarter_rom();
  localparam mag_t         QUARTER_PEAK = mag_t'(quarter_sine(longint'(QUARTER_SIZE)));

endpackage

`default_nettype wire

### rtl/core/bitg_sine_rom.sv
`default_nettype none

module bitg_sine_rom (
  input  wire                       clk,
  input  wire                       rd_en,
  input  wire bitg_pkg::sine_addr_t rd_addr_a,
  input  wire bitg_pkg::sine_addr_t rd_addr_b,
  output bitg_pkg::sample_t         rd_data_a,
  output bitg_pkg::sample_t         rd_data_b
);

  import bitg_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  sample_t rd_data_a_r;
  sample_t rd_data_b_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= SINE_ROM[rd_addr_a];
      rd_data_b_r <= SINE_ROM[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

`default_nettype wire

### rtl/core/binaural_itd_tone_generator.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_frame_request
// out_      output     out_valid / out_stall out_left_sample, out_right_sample, out_buffer_end
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One frame is taken per cycle while in_stall is low; its result passes through stages s1,
// s2 and s3 and is presented by the registered read of the dual-port sine table.
// Reset is synchronous and active low; it restores the register defaults and clears the
// phase, angle and frame count. No clearing pass is needed.
// Each stage holds its frame only while the stage after it is full and stalled, so
// input stalls only when all four stages are full and out_stall is high.

module binaural_itd_tone_generator (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_frame_request,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output bitg_pkg::sample_t                    out_left_sample,
  output bitg_pkg::sample_t                    out_right_sample,
  output logic                                 out_buffer_end,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [bitg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire [bitg_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  import bitg_pkg::*;

  logic [STEP_BITS-1:0]  tone_step_r;
  logic [GAIN_BITS-1:0]  itd_gain_r;
  logic [ANGLE_BITS-1:0] angle_step_r;
  logic [COUNT_BITS-1:0] frames_per_buffer_r;

  logic [PHASE_BITS-1:0] tone_phase_r;
  logic [PHASE_BITS-1:0] tone_phase_nxt;
  logic [ANGLE_BITS-1:0] source_angle_r;
  logic [ANGLE_BITS-1:0] source_angle_nxt;
  logic [COUNT_BITS-1:0] frame_count_r;
  logic [COUNT_BITS-1:0] frame_count_nxt;
  logic [PHASE_BITS-1:0] ear_offset_r;

  logic                  s1_valid_r;
  logic [PHASE_BITS-1:0] s1_phase_r;
  logic                  s1_first_r;
  logic                  s1_neg_r;
  mag_t                  s1_mag_r;
  logic                  s1_last_r;

  logic                  s2_valid_r;
  logic [PHASE_BITS-1:0] s2_phase_r;
  logic                  s2_first_r;
  logic                  s2_neg_r;
  logic [PROD_BITS-1:0]  s2_prod_r;
  logic                  s2_last_r;

  logic                  s3_valid_r;
  sine_addr_t            s3_left_addr_r;
  sine_addr_t            s3_right_addr_r;
  logic                  s3_last_r;

  logic                  out_valid_r;
  logic                  out_last_r;

  logic out_en;
  logic s3_en;
  logic s2_en;
  logic s1_en;
  logic acc_frame;
  logic out_take;

  logic [COUNT_BITS-1:0]     fc_inc;
  logic                      last;
  logic                      first;
  sine_addr_t                angle_idx;
  logic [1:0]                angle_quad;
  logic [QUARTER_BITS:0]     q_idx;
  mag_t                      angle_mag;

  logic [PHASE_BITS-1:0]     off_mag;
  logic [PHASE_BITS-1:0]     off_signed;
  logic [PHASE_BITS-1:0]     eo;
  logic [PHASE_BITS-1:0]     left_phase;
  logic [PHASE_BITS-1:0]     right_phase;

  localparam logic [QUARTER_BITS:0] Q_FULL = (QUARTER_BITS + 1)'(QUARTER_SIZE);

  assign out_en    = !out_valid_r || !out_stall;
  assign s3_en     = !s3_valid_r || out_en;
  assign s2_en     = !s2_valid_r || s3_en;
  assign s1_en     = !s1_valid_r || s2_en;
  assign in_stall  = !s1_en;
  assign acc_frame = in_valid && !in_stall && in_frame_request;
  assign out_take  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  assign fc_inc = frame_count_r + 1'b1;
  assign last   = (fc_inc >= frames_per_buffer_r) || (fc_inc == '0);
  assign first  = (frame_count_r == '0);

  assign angle_idx  = source_angle_r[ANGLE_BITS-1 -: SINE_ADDR_BITS];
  assign angle_quad = angle_idx[SINE_ADDR_BITS-1 -: 2];
  assign q_idx      = angle_quad[0] ? (Q_FULL - {1'b0, angle_idx[QUARTER_BITS-1:0]})
                                    : {1'b0, angle_idx[QUARTER_BITS-1:0]};
  assign angle_mag  = q_idx[QUARTER_BITS] ? QUARTER_PEAK
                                          : QUARTER_ROM[q_idx[QUARTER_BITS-1:0]];

  assign tone_phase_nxt   = tone_phase_r + PHASE_BITS'(tone_step_r);
  assign frame_count_nxt  = last ? '0 : fc_inc;
  assign source_angle_nxt = last ? (source_angle_r + angle_step_r) : source_angle_r;

  generate
    if (OFF_SHIFT >= 0) begin : g_off_up
      assign off_mag = PHASE_BITS'(s2_prod_r) << OFF_SHIFT;
    end else begin : g_off_down
      localparam int RSH = -OFF_SHIFT;
      logic [PROD_BITS:0] prod_rnd;
      assign prod_rnd = {1'b0, s2_prod_r} + ((PROD_BITS + 1)'(1) << (RSH - 1));
      assign off_mag  = PHASE_BITS'(prod_rnd >> RSH);
    end
  endgenerate

  assign off_signed  = s2_neg_r ? (PHASE_BITS'(0) - off_mag) : off_mag;
  assign eo          = s2_first_r ? off_signed : ear_offset_r;
  assign left_phase  = s2_phase_r - eo;
  assign right_phase = s2_phase_r + eo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_step_r         <= TONE_STEP_RST;
      itd_gain_r          <= ITD_GAIN_RST;
      angle_step_r        <= ANGLE_STEP_RST;
      frames_per_buffer_r <= FRAMES_PER_BUF_RST;
      tone_phase_r        <= '0;
      source_angle_r      <= '0;
      frame_count_r       <= '0;
      ear_offset_r        <= '0;
      s1_valid_r          <= 1'b0;
      s2_valid_r          <= 1'b0;
      s3_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_TONE_STEP:  tone_step_r         <= STEP_BITS'(cfg_data);
          CFG_ITD_GAIN:   itd_gain_r          <= GAIN_BITS'(cfg_data);
          CFG_ANGLE_STEP: angle_step_r        <= ANGLE_BITS'(cfg_data);
          CFG_FRAMES:     frames_per_buffer_r <= COUNT_BITS'(cfg_data);
          default: begin
          end
        endcase
      end
      if (acc_frame) begin
        tone_phase_r   <= tone_phase_nxt;
        frame_count_r  <= frame_count_nxt;
        source_angle_r <= source_angle_nxt;
      end
      if (s3_en && s2_valid_r && s2_first_r) begin
        ear_offset_r <= off_signed;
      end
      if (s1_en) begin
        s1_valid_r <= acc_frame;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_en) begin
        s3_valid_r <= s2_valid_r;
      end
      if (out_en) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_phase_r <= tone_phase_r;
      s1_first_r <= first;
      s1_neg_r   <= angle_quad[1];
      s1_mag_r   <= angle_mag;
      s1_last_r  <= last;
    end
    if (s2_en) begin
      s2_phase_r <= s1_phase_r;
      s2_first_r <= s1_first_r;
      s2_neg_r   <= s1_neg_r;
      s2_prod_r  <= PROD_BITS'(itd_gain_r) * PROD_BITS'(s1_mag_r);
      s2_last_r  <= s1_last_r;
    end
    if (s3_en) begin
      s3_left_addr_r  <= left_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
      s3_right_addr_r <= right_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
      s3_last_r       <= s2_last_r;
    end
    if (out_en) begin
      out_last_r <= s3_last_r;
    end
  end

  bitg_sine_rom u_sine_rom (
    .clk       (clk),
    .rd_en     (out_en),
    .rd_addr_a (s3_left_addr_r),
    .rd_addr_b (s3_right_addr_r),
    .rd_data_a (out_left_sample),
    .rd_data_b (out_right_sample)
  );

  assign out_valid      = out_valid_r;
  assign out_buffer_end = out_last_r;

  logic [2:0] occupancy;
  assign occupancy = 3'(s1_valid_r) + 3'(s2_valid_r) + 3'(s3_valid_r) + 3'(out_valid_r);

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && s3_valid_r && out_valid_r && out_stall))
    else $error("Input stalled while the pipeline had room.");

  a_frame_conservation: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      occupancy == $past(occupancy) + 3'($past(acc_frame)) - 3'($past(out_take)))
    else $error("A frame was lost or duplicated in the pipeline.");

  a_angle_moves_on_buffer_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(acc_frame && last)) |-> $stable(source_angle_r))
    else $error("Source angle changed outside a buffer end.");

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bitg_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_TICKS = 8;
  localparam int PHASE_COUNT  = 10;
  localparam int PHASE_FRAMES = 130;
  localparam int ROW_COUNT    = 31;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    bend;
  } stereo_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_FRAME,
    ROW_NOREQ
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    sel;
    logic [31:0] data;
    logic        fixed;
    stereo_t     want;
  } stim_row_t;

  localparam stereo_t NONE = '{16'sd0, 16'sd0, 1'b0};

  // Fixed rows start from the reset state or from a quarter-turn tone step with no
  // interaural offset, so their samples sit at the sine peaks and zero crossings.
  localparam stim_row_t DIRECTED [ROW_COUNT] = '{
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b1, '{16'sd0, 16'sd0, 1'b0}},
    '{ROW_WRITE, CFG_TONE_STEP,  32'h0 - 32'd42852281,    1'b0, NONE},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b0, NONE},
    '{ROW_WRITE, CFG_TONE_STEP,  32'h4000_0000,           1'b0, NONE},
    '{ROW_WRITE, CFG_ITD_GAIN,   32'hABCD_0000,           1'b0, NONE},
    '{ROW_WRITE, CFG_FRAMES,     32'h0000_0001,           1'b0, NONE},
    '{ROW_WRITE, CFG_ANGLE_STEP, 32'hFFFF_FFFF,           1'b0, NONE},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b1, '{16'sd0, 16'sd0, 1'b1}},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b1, '{16'sd32767, 16'sd32767, 1'b1}},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b1, '{16'sd0, 16'sd0, 1'b1}},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b1, '{-16'sd32767, -16'sd32767, 1'b1}},
    '{ROW_NOREQ, CFG_TONE_STEP,  32'h0,                   1'b0, NONE},
    '{ROW_WRITE, CFG_FRAMES,     32'h5A5A_0000,           1'b0, NONE},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b1, '{16'sd0, 16'sd0, 1'b1}},
    '{ROW_WRITE, CFG_ITD_GAIN,   32'hFFFF_FFFF,           1'b0, NONE},
    '{ROW_WRITE, CFG_TONE_STEP,  32'hFFFF_FFFF,           1'b0, NONE},
    '{ROW_WRITE, CFG_FRAMES,     32'h0000_FFFF,           1'b0, NONE},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b0, NONE},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b0, NONE},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b0, NONE},
    '{ROW_NOREQ, CFG_TONE_STEP,  32'h0,                   1'b0, NONE},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b0, NONE},
    '{ROW_WRITE, CFG_FRAMES,     32'h0000_0002,           1'b0, NONE},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b0, NONE},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b0, NONE},
    '{ROW_WRITE, CFG_ANGLE_STEP, 32'h0000_4000,           1'b0, NONE},
    '{ROW_WRITE, CFG_FRAMES,     32'h0000_0001,           1'b0, NONE},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b0, NONE},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b0, NONE},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b0, NONE},
    '{ROW_FRAME, CFG_TONE_STEP,  32'h0,                   1'b0, NONE}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_frame_request = 1'b0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = 2'b00;
  logic [31:0] cfg_data = 32'h0;
  logic        in_stall;
  logic        out_valid;
  sample_t     out_left_sample;
  sample_t     out_right_sample;
  logic        out_buffer_end;
  logic        cfg_ready;

  bit          calm = 1'b0;
  int          quiet_cycles = 0;
  int          mismatches = 0;
  stereo_t     pending_frames [$];

  sample_t     wave_table [1024];
  logic [31:0] step_cfg;
  logic [15:0] gain_cfg;
  logic [15:0] angle_cfg;
  logic [15:0] frames_cfg;
  logic [31:0] osc_phase;
  logic [15:0] src_angle;
  logic [15:0] frame_in_buf;
  logic [31:0] ear_shift;

  binaural_itd_tone_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_request (in_frame_request),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_buffer_end   (out_buffer_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint quarter_wave(longint r);
    longint ang;
    longint ang_sq;
    longint t;
    longint acc;
    longint scaled;
    ang    = (r * 64'sd1686629713 + 64'sd128) / 64'sd256;
    ang_sq = (ang * ang + (64'sd1 << 29)) >> 30;
    t      = ang;
    acc    = ang;
    for (int k = 1; k <= 6; k++) begin
      t = ((t * ang_sq) >> 30) / longint'(2 * k * (2 * k + 1));
      acc = (k % 2 == 1) ? acc - t : acc + t;
    end
    if (acc < 0) begin
      acc = 0;
    end
    scaled = (acc * 64'sd32767 + (64'sd1 << 29)) >> 30;
    return (scaled > 32767) ? 64'sd32767 : scaled;
  endfunction

  function automatic void fill_wave_table();
    longint mag;
    for (int idx = 0; idx < 1024; idx++) begin
      mag = (idx & 256) != 0 ? quarter_wave(256 - (idx & 255)) : quarter_wave(idx & 255);
      wave_table[idx] = sample_t'((idx & 512) != 0 ? -mag : mag);
    end
  endfunction

  function automatic stereo_t synth_frame();
    stereo_t     res;
    int          tilt;
    logic [31:0] lpos;
    logic [31:0] rpos;
    if (frame_in_buf == 16'd0) begin
      tilt = wave_table[src_angle[15:6]];
      ear_shift = (32'(gain_cfg) * 32'(tilt < 0 ? -tilt : tilt)) << 1;
      if (tilt < 0) begin
        ear_shift = 32'h0 - ear_shift;
      end
    end
    lpos = osc_phase - ear_shift;
    rpos = osc_phase + ear_shift;
    res.left  = wave_table[lpos[31:22]];
    res.right = wave_table[rpos[31:22]];
    osc_phase = osc_phase + step_cfg;
    frame_in_buf = frame_in_buf + 16'd1;
    res.bend = (frame_in_buf >= frames_cfg) || (frame_in_buf == 16'd0);
    if (res.bend) begin
      frame_in_buf = 16'd0;
      src_angle = src_angle + angle_cfg;
    end
    return res;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [31:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (sel)
      CFG_TONE_STEP:  step_cfg   = data;
      CFG_ITD_GAIN:   gain_cfg   = data[15:0];
      CFG_ANGLE_STEP: angle_cfg  = data[15:0];
      CFG_FRAMES:     frames_cfg = data[15:0];
      default: ;
    endcase
  endtask

  task automatic send_frame(logic req, logic fixed, stereo_t want);
    stereo_t pred;
    in_valid         <= 1'b1;
    in_frame_request <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (req) begin
      pred = synth_frame();
      pending_frames.push_back(fixed ? want : pred);
    end
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 9);
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    stereo_t exp_frame;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected transaction left %0d right %0d end %0b", $time,
                 out_left_sample, out_right_sample, out_buffer_end);
        mismatches++;
      end else begin
        exp_frame = pending_frames.pop_front();
        if (out_left_sample !== exp_frame.left) begin
          $display("%0t: left_sample expected %0d actual %0d", $time, exp_frame.left,
                   out_left_sample);
          mismatches++;
        end
        if (out_right_sample !== exp_frame.right) begin
          $display("%0t: right_sample expected %0d actual %0d", $time, exp_frame.right,
                   out_right_sample);
          mismatches++;
        end
        if (out_buffer_end !== exp_frame.bend) begin
          $display("%0t: buffer_end expected %0b actual %0b", $time, exp_frame.bend,
                   out_buffer_end);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int          sent;
    logic        req;
    logic [15:0] frames_val;
    fill_wave_table();
    step_cfg     = 32'd42852281;
    gain_cfg     = 16'd17288;
    angle_cfg    = 16'd104;
    frames_cfg   = 16'd256;
    osc_phase    = '0;
    src_angle    = '0;
    frame_in_buf = '0;
    ear_shift    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      case (DIRECTED[i].kind)
        ROW_WRITE: write_reg(DIRECTED[i].sel, DIRECTED[i].data);
        ROW_FRAME: send_frame(1'b1, DIRECTED[i].fixed, DIRECTED[i].want);
        default:   send_frame(1'b0, 1'b0, NONE);
      endcase
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case ($urandom_range(0, 9))
        0: frames_val = 16'h0000;
        1: frames_val = 16'hFFFF;
        2: frames_val = 16'($urandom);
        default: frames_val = 16'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(CFG_TONE_STEP, 32'h0);
        1: write_reg(CFG_TONE_STEP, 32'hFFFF_FFFF);
        default: write_reg(CFG_TONE_STEP, $urandom);
      endcase
      write_reg(CFG_ITD_GAIN, {16'($urandom), pick16()});
      write_reg(CFG_ANGLE_STEP, {16'($urandom), pick16()});
      write_reg(CFG_FRAMES, {16'($urandom), frames_val});
      calm <= (p == 4 || p == 5);
      sent = 0;
      while (sent < PHASE_FRAMES) begin
        req = ($urandom_range(0, 9) != 0);
        send_frame(req, 1'b0, NONE);
        sent++;
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
